// ----- design/csd_pkg.sv -----
`timescale 1ns / 1ps

package csd_pkg;

  // Register index codes, taken from paddr[2] (word aligned map)
  localparam logic REG_LOCK_SECONDS = 1'b0;
  localparam logic REG_DRIFT_LIMIT  = 1'b1;

  localparam logic [7:0]  LOCK_SECONDS_RESET = 8'd5;
  localparam logic [16:0] DRIFT_LIMIT_RESET  = 17'd3;

  // Tick and manual clock set codes of the action field
  localparam logic ACTION_TICK   = 1'b0;
  localparam logic ACTION_MANUAL = 1'b1;

  // Remote date window
  localparam logic [15:0] YEAR_MIN = 16'd2000;
  localparam logic [15:0] YEAR_MAX = 16'd2099;
  // Base year for the weekday sum; multiple of 4 below YEAR_MIN - 1
  localparam logic [15:0] YEAR_BASE = 16'd1996;
  // (7000 + 1996 + 1996/4 - 15) mod 7; century terms fold to -15 in the window
  localparam logic [7:0]  DOW_BIAS = 8'd2;

  typedef struct packed {
    logic [7:0]  lock_seconds;
    logic [16:0] drift_limit;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic        link_ok;
    logic [16:0] local_second_of_day;
    logic [4:0]  local_day;
    logic [3:0]  local_month;
    logic [11:0] local_year;
    logic [7:0]  remote_hour;
    logic [7:0]  remote_minute;
    logic [7:0]  remote_second;
    logic [7:0]  remote_day;
    logic [7:0]  remote_month;
    logic [15:0] remote_year;
  } item_t;

  typedef struct packed {
    logic       set_date;
    logic       set_time;
    logic [2:0] day_of_week;
    logic [8:0] day_of_year;
    logic [7:0] lock_remaining;
  } result_t;

  // Days in the year before the first of month m
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // floor(31 * mm / 12) for the March-based month mm
  function automatic logic [4:0] month_offset(input logic [3:0] mm);
    logic [4:0] r;
    case (mm)
      4'd1:    r = 5'd2;
      4'd2:    r = 5'd5;
      4'd3:    r = 5'd7;
      4'd4:    r = 5'd10;
      4'd5:    r = 5'd12;
      4'd6:    r = 5'd15;
      4'd7:    r = 5'd18;
      4'd8:    r = 5'd20;
      4'd9:    r = 5'd23;
      4'd10:   r = 5'd25;
      4'd11:   r = 5'd28;
      4'd12:   r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Remainder by 7: fold base-64 and base-8 digits (both are 1 mod 7)
  function automatic logic [2:0] mod7(input logic [7:0] v);
    logic [6:0] a;
    logic [3:0] b;
    logic [3:0] c;
    a = {5'd0, v[7:6]} + {1'b0, v[5:0]};
    b = a[6:3] + {1'b0, a[2:0]};
    c = (b >= 4'd7) ? b - 4'd7 : b;
    c = (c >= 4'd7) ? c - 4'd7 : c;
    return c[2:0];
  endfunction

endpackage

// ----- design/csd_regs.sv -----
`timescale 1ns / 1ps

module csd_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output csd_pkg::cfg_t       cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lock_seconds <= csd_pkg::LOCK_SECONDS_RESET;
      cfg.drift_limit  <= csd_pkg::DRIFT_LIMIT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        csd_pkg::REG_LOCK_SECONDS: cfg.lock_seconds <= pwdata[7:0];
        csd_pkg::REG_DRIFT_LIMIT:  cfg.drift_limit  <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[2])
      csd_pkg::REG_LOCK_SECONDS: prdata = {24'd0, cfg.lock_seconds};
      csd_pkg::REG_DRIFT_LIMIT:  prdata = {15'd0, cfg.drift_limit};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// ----- design/csd_eval.sv -----
`timescale 1ns / 1ps

module csd_eval (
  input  csd_pkg::item_t   item,
  input  csd_pkg::cfg_t    cfg,
  input  logic [7:0]       lock,
  output csd_pkg::result_t res
);

  logic        date_diff;
  logic        date_ok;
  logic        date_hit;
  logic        time_ok;
  logic        time_hit;
  logic [7:0]  lock_dec;
  logic [7:0]  lock_mid;
  logic        jan_feb;
  logic [15:0] yy;
  logic [15:0] t_full;
  logic [6:0]  t;
  logic [3:0]  mm;
  logic [7:0]  dow_sum;
  logic        leap;
  logic [8:0]  doy;
  logic [19:0] rsod;
  logic [19:0] lsod;
  logic [19:0] diff;

  // Count the lock down, never below zero
  assign lock_dec = (lock != 8'd0) ? lock - 8'd1 : 8'd0;

  // Date check
  assign date_diff = (item.remote_day != {3'd0, item.local_day}) ||
                     (item.remote_month != {4'd0, item.local_month}) ||
                     (item.remote_year != {4'd0, item.local_year});
  assign date_ok   = (item.remote_day >= 8'd1) && (item.remote_day <= 8'd31) &&
                     (item.remote_month >= 8'd1) && (item.remote_month <= 8'd12) &&
                     (item.remote_year >= csd_pkg::YEAR_MIN) &&
                     (item.remote_year <= csd_pkg::YEAR_MAX);
  assign date_hit  = item.link_ok && (lock_dec == 8'd0) && date_diff && date_ok;
  assign lock_mid  = date_hit ? cfg.lock_seconds : lock_dec;

  // Weekday: March-based year, offset from the base year
  assign jan_feb = (item.remote_month[3:0] <= 4'd2);
  assign yy      = item.remote_year - {15'd0, jan_feb};
  assign t_full  = yy - csd_pkg::YEAR_BASE;
  assign t       = t_full[6:0];
  assign mm      = jan_feb ? item.remote_month[3:0] + 4'd10 : item.remote_month[3:0] - 4'd2;
  assign dow_sum = csd_pkg::DOW_BIAS + {3'd0, item.remote_day[4:0]} + {1'b0, t} +
                   {3'd0, t[6:2]} + {3'd0, csd_pkg::month_offset(mm)};

  // Ordinal day; every year divisible by 4 in the window is a leap year
  assign leap = (item.remote_year[1:0] == 2'd0);
  assign doy  = {4'd0, item.remote_day[4:0]} + csd_pkg::days_before(item.remote_month[3:0]) +
                {8'd0, (item.remote_month[3:0] > 4'd2) && leap};

  // Time check
  assign rsod = ({12'd0, item.remote_hour} * 20'd3600) +
                ({12'd0, item.remote_minute} * 20'd60) +
                {12'd0, item.remote_second};
  assign lsod = {3'd0, item.local_second_of_day};
  assign diff = (lsod > rsod) ? lsod - rsod : rsod - lsod;
  assign time_ok = (item.remote_hour >= 8'd1) && (item.remote_hour <= 8'd23) &&
                   (item.remote_minute >= 8'd1) && (item.remote_minute <= 8'd59) &&
                   (item.remote_second >= 8'd1) && (item.remote_second <= 8'd59);
  assign time_hit = item.link_ok && (lock_mid == 8'd0) && (rsod != 20'd0) &&
                    (diff > {3'd0, cfg.drift_limit}) && time_ok;

  // Assemble the result word
  always_comb begin
    if (item.action == csd_pkg::ACTION_MANUAL) begin
      res.set_date       = 1'b0;
      res.set_time       = 1'b0;
      res.day_of_week    = 3'd0;
      res.day_of_year    = 9'd0;
      res.lock_remaining = cfg.lock_seconds;
    end else begin
      res.set_date       = date_hit;
      res.set_time       = time_hit;
      res.day_of_week    = date_hit ? csd_pkg::mod7(dow_sum) : 3'd0;
      res.day_of_year    = date_hit ? doy : 9'd0;
      res.lock_remaining = time_hit ? cfg.lock_seconds : lock_mid;
    end
  end

endmodule

// ----- design/clock_sync_decider.sv -----
`timescale 1ns / 1ps
// Path: each word is registered in the input register, then in the result
// register, and waits in the input register while the result is not taken.
// Throughput: one word per cycle while out_ready does not stall; the lock counter
// updates once per evaluated word in the result stage.
// Reset (synchronous, rst high): both stages empty, lock counter 0,
// lock_seconds 5, drift_limit 3.

module clock_sync_decider (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic        link_ok,
  input  logic [16:0] local_second_of_day,
  input  logic [4:0]  local_day,
  input  logic [3:0]  local_month,
  input  logic [11:0] local_year,
  input  logic [7:0]  remote_hour,
  input  logic [7:0]  remote_minute,
  input  logic [7:0]  remote_second,
  input  logic [7:0]  remote_day,
  input  logic [7:0]  remote_month,
  input  logic [15:0] remote_year,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        set_date,
  output logic        set_time,
  output logic [2:0]  day_of_week,
  output logic [8:0]  day_of_year,
  output logic [7:0]  lock_remaining,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  csd_pkg::cfg_t    cfg;
  csd_pkg::item_t   item_q;
  csd_pkg::result_t res;
  csd_pkg::result_t res_q;
  logic             item_valid;
  logic             advance;
  logic [7:0]       lock;

  csd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csd_eval u_eval (
    .item (item_q),
    .cfg  (cfg),
    .lock (lock),
    .res  (res)
  );

  // Move a word into the result stage when it is empty or draining
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= '{action: action, link_ok: link_ok,
                  local_second_of_day: local_second_of_day,
                  local_day: local_day, local_month: local_month,
                  local_year: local_year, remote_hour: remote_hour,
                  remote_minute: remote_minute, remote_second: remote_second,
                  remote_day: remote_day, remote_month: remote_month,
                  remote_year: remote_year};
    end
  end

  // Result stage and lock counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      lock      <= 8'd0;
    end else if (advance) begin
      out_valid <= 1'b1;
      lock      <= res.lock_remaining;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign set_date       = res_q.set_date;
  assign set_time       = res_q.set_time;
  assign day_of_week    = res_q.day_of_week;
  assign day_of_year    = res_q.day_of_year;
  assign lock_remaining = res_q.lock_remaining;

endmodule

// ----- bench/clock_sync_decider_tb.sv -----
`timescale 1ns / 1ps

module clock_sync_decider_tb;

  // Expected decisions per accepted word; tracks the lock counter and both registers
  class sync_verdicts;
    logic [7:0]       lock_sec;
    logic [16:0]      drift_lim;
    logic [7:0]       lock_cnt;
    csd_pkg::result_t due[$];
    int unsigned      bad_count;

    function new();
      lock_sec  = csd_pkg::LOCK_SECONDS_RESET;
      drift_lim = csd_pkg::DRIFT_LIMIT_RESET;
      lock_cnt  = '0;
      bad_count = 0;
    endfunction

    function void set_config(logic idx, logic [31:0] v);
      if (idx == csd_pkg::REG_LOCK_SECONDS) begin
        lock_sec = v[7:0];
      end else begin
        drift_lim = v[16:0];
      end
    endfunction

    // Weekday, 0 Sunday; January and February count as months of the prior year
    function int unsigned weekday(int unsigned d, int unsigned m, int unsigned y);
      int unsigned yy;
      int unsigned mm;
      if (m < 3) begin
        yy = y - 1;
        mm = m + 10;
      end else begin
        yy = y;
        mm = m - 2;
      end
      return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
    endfunction

    // Ordinal day; the day is not checked against the month length
    function int unsigned ordinal(int unsigned d, int unsigned m, int unsigned y);
      int unsigned month_start[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                       304, 334};
      int unsigned r;
      r = d + month_start[m - 1];
      if (m > 2 && (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) begin
        r++;
      end
      return r;
    endfunction

    function void note_word(csd_pkg::item_t w);
      csd_pkg::result_t r;
      int unsigned      rsod;
      int unsigned      diff;
      int unsigned      lsod;
      r = '0;
      lsod = w.local_second_of_day;
      if (w.action == csd_pkg::ACTION_MANUAL) begin
        lock_cnt = lock_sec;
      end else begin
        if (lock_cnt != 0) begin
          lock_cnt--;
        end
        if (w.link_ok) begin
          // Date check: differing, valid remote date
          if (lock_cnt == 0 &&
              (w.remote_day != w.local_day || w.remote_month != w.local_month ||
               w.remote_year != w.local_year) &&
              w.remote_day >= 1 && w.remote_day <= 31 &&
              w.remote_month >= 1 && w.remote_month <= 12 &&
              w.remote_year >= 2000 && w.remote_year <= 2099) begin
            r.set_date    = 1'b1;
            r.day_of_week = 3'(weekday(w.remote_day, w.remote_month, w.remote_year));
            r.day_of_year = 9'(ordinal(w.remote_day, w.remote_month, w.remote_year));
            lock_cnt = lock_sec;
          end
          // Time check on the raw remote fields
          rsod = w.remote_hour * 3600 + w.remote_minute * 60 + w.remote_second;
          diff = (lsod > rsod) ? lsod - rsod : rsod - lsod;
          if (lock_cnt == 0 && rsod != 0 && diff > drift_lim &&
              w.remote_hour >= 1 && w.remote_hour <= 23 &&
              w.remote_minute >= 1 && w.remote_minute <= 59 &&
              w.remote_second >= 1 && w.remote_second <= 59) begin
            r.set_time = 1'b1;
            lock_cnt = lock_sec;
          end
        end
      end
      r.lock_remaining = lock_cnt;
      due.push_back(r);
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
        bad_count++;
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, seen);
      end
    endfunction

    function void check_word(csd_pkg::result_t got);
      csd_pkg::result_t want;
      if (due.size() == 0) begin
        bad_count++;
        $display("%0t result word with nothing expected: actual %h", $time, got);
        return;
      end
      want = due.pop_front();
      cmp_field("set_date", want.set_date, got.set_date);
      cmp_field("set_time", want.set_time, got.set_time);
      cmp_field("day_of_week", want.day_of_week, got.day_of_week);
      cmp_field("day_of_year", want.day_of_year, got.day_of_year);
      cmp_field("lock_remaining", want.lock_remaining, got.lock_remaining);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  csd_pkg::item_t   drv = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             set_date;
  logic             set_time;
  logic [2:0]       day_of_week;
  logic [8:0]       day_of_year;
  logic [7:0]       lock_remaining;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  csd_pkg::result_t got_word;

  sync_verdicts sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_req = 1'b0;

  assign got_word = {set_date, set_time, day_of_week, day_of_year, lock_remaining};

  clock_sync_decider DUT (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .action              (drv.action),
    .link_ok             (drv.link_ok),
    .local_second_of_day (drv.local_second_of_day),
    .local_day           (drv.local_day),
    .local_month         (drv.local_month),
    .local_year          (drv.local_year),
    .remote_hour         (drv.remote_hour),
    .remote_minute       (drv.remote_minute),
    .remote_second       (drv.remote_second),
    .remote_day          (drv.remote_day),
    .remote_month        (drv.remote_month),
    .remote_year         (drv.remote_year),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .set_date            (set_date),
    .set_time            (set_time),
    .day_of_week         (day_of_week),
    .day_of_year         (day_of_year),
    .lock_remaining      (lock_remaining),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Note accepted words, then check delivered results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_word(drv);
      end
      if (out_valid && out_ready) begin
        sb.check_word(got_word);
      end
    end
  end

  // Drive out_ready; hold it low for a long stretch on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  function automatic csd_pkg::item_t make_word(int act, int lnk, int lsod, int ld, int lm,
                                               int ly, int rh, int rmi, int rs, int rd,
                                               int rmo, int ry);
    csd_pkg::item_t w;
    w.action              = 1'(act);
    w.link_ok             = 1'(lnk);
    w.local_second_of_day = 17'(lsod);
    w.local_day           = 5'(ld);
    w.local_month         = 4'(lm);
    w.local_year          = 12'(ly);
    w.remote_hour         = 8'(rh);
    w.remote_minute       = 8'(rmi);
    w.remote_second       = 8'(rs);
    w.remote_day          = 8'(rd);
    w.remote_month        = 8'(rmo);
    w.remote_year         = 16'(ry);
    return w;
  endfunction

  // Mostly well-formed dates and times, with local time near the drift limit for half of the words
  function automatic csd_pkg::item_t rand_word(input int unsigned drift);
    csd_pkg::item_t w;
    int unsigned    pick;
    int unsigned    rsod;
    int             near;
    w = '0;
    w.action      = ($urandom_range(0, 99) < 8) ? csd_pkg::ACTION_MANUAL
                                                : csd_pkg::ACTION_TICK;
    w.link_ok     = ($urandom_range(0, 99) < 85);
    w.local_day   = 5'($urandom_range(1, 31));
    w.local_month = 4'($urandom_range(1, 12));
    w.local_year  = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
                                                : 12'($urandom_range(1998, 2101));
    // Remote date
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      w.remote_day   = 8'($urandom_range(1, 31));
      w.remote_month = 8'($urandom_range(1, 12));
      w.remote_year  = 16'($urandom_range(2000, 2099));
    end else if (pick < 8) begin
      w.remote_day   = {3'd0, w.local_day};
      w.remote_month = {4'd0, w.local_month};
      w.remote_year  = {4'd0, w.local_year};
    end else if (pick == 8) begin
      w.remote_day   = 8'($urandom_range(0, 255));
      w.remote_month = 8'($urandom_range(0, 255));
      w.remote_year  = 16'($urandom_range(0, 65535));
    end else begin
      w.remote_day   = 8'($urandom_range(1, 31));
      w.remote_month = 8'($urandom_range(1, 12));
      w.remote_year  = 16'($urandom_range(2000, 2099));
      case ($urandom_range(0, 5))
        0:       w.remote_day = 8'd0;
        1:       w.remote_day = 8'd32;
        2:       w.remote_month = 8'd0;
        3:       w.remote_month = 8'd13;
        4:       w.remote_year = 16'd1999;
        default: w.remote_year = 16'd2100;
      endcase
    end
    // Remote time
    pick = $urandom_range(0, 9);
    if (pick == 8) begin
      w.remote_hour   = 8'($urandom_range(0, 255));
      w.remote_minute = 8'($urandom_range(0, 255));
      w.remote_second = 8'($urandom_range(0, 255));
    end else begin
      w.remote_hour   = 8'($urandom_range(1, 23));
      w.remote_minute = 8'($urandom_range(1, 59));
      w.remote_second = 8'($urandom_range(1, 59));
      if (pick == 7) begin
        case ($urandom_range(0, 2))
          0:       w.remote_hour = 8'd0;
          1:       w.remote_minute = 8'd0;
          default: w.remote_second = 8'd0;
        endcase
      end else if (pick == 9) begin
        case ($urandom_range(0, 2))
          0:       w.remote_hour = 8'd24;
          1:       w.remote_minute = 8'd60;
          default: w.remote_second = 8'd60;
        endcase
      end
    end
    // Local time: half of the words land around the drift limit
    rsod = w.remote_hour * 3600 + w.remote_minute * 60 + w.remote_second;
    if ($urandom_range(0, 1)) begin
      near = int'(rsod) + int'($urandom_range(0, 2 * drift + 4)) - int'(drift) - 2;
      if (near < 0) near = 0;
      if (near > 86399) near = 86399;
      w.local_second_of_day = 17'(near);
    end else begin
      w.local_second_of_day = 17'($urandom_range(0, 86399));
    end
    return w;
  endfunction

  // Offer one word, idling first at the sender's rate; return at a falling edge
  task automatic send_word(input csd_pkg::item_t w);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    drv <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected word is back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Write one register; return at a falling edge with the bus idle
  task automatic write_reg(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_config(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int unsigned lock_plan[8]   = '{255, 0, 1, 0, 3, 0, 2, 128};
    int unsigned drift_plan[8]  = '{86399, 0, 3, 86398, 60, 1, 0, 5};
    int          idle_plan[8]   = '{0, 67, 0, 17, 0, 67, 0, 17};
    int          stall_plan[8]  = '{0, 0, 67, 17, 0, 0, 67, 17};
    bit          hold_plan[8]   = '{1, 0, 0, 0, 1, 0, 0, 0};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Lock behavior under reset settings: date set, manual set, countdown
    send_word(make_word(csd_pkg::ACTION_TICK, 1, 43200, 15, 6, 2030, 12, 0, 0, 29, 2, 2024));
    send_word(make_word(csd_pkg::ACTION_MANUAL, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0));
    repeat (5) send_word(make_word(csd_pkg::ACTION_TICK, 1, 100, 1, 1, 2000, 10, 20, 30,
                                   2, 1, 2000));
    drain();

    // Zero lock length and zero drift limit: date and time edge cases
    write_reg(csd_pkg::REG_LOCK_SECONDS, 32'd0);
    write_reg(csd_pkg::REG_DRIFT_LIMIT, 32'd0);
    send_word(make_word(csd_pkg::ACTION_TICK, 0, 0, 1, 1, 2000, 10, 10, 10, 5, 5, 2050));
    send_word(make_word(csd_pkg::ACTION_TICK, 1, 0, 15, 6, 2030, 10, 10, 10, 15, 6, 2030));
    send_word(make_word(csd_pkg::ACTION_TICK, 1, 43200, 1, 1, 2000, 0, 30, 30, 31, 2, 2024));
    send_word(make_word(csd_pkg::ACTION_TICK, 1, 43200, 1, 1, 2000, 12, 30, 30, 31, 12,
                        2099));
    send_word(make_word(csd_pkg::ACTION_TICK, 1, 0, 15, 6, 2030, 1, 1, 1, 1, 1, 2000));
    send_word(make_word(csd_pkg::ACTION_TICK, 1, 0, 15, 6, 2030, 1, 1, 1, 1, 3, 2000));
    send_word(make_word(csd_pkg::ACTION_TICK, 1, 0, 15, 6, 2030, 1, 1, 1, 1, 3, 1999));
    send_word(make_word(csd_pkg::ACTION_TICK, 1, 0, 15, 6, 2030, 1, 1, 1, 1, 3, 2100));
    send_word(make_word(csd_pkg::ACTION_TICK, 1, 0, 15, 6, 2030, 1, 1, 1, 0, 3, 2001));
    send_word(make_word(csd_pkg::ACTION_TICK, 1, 0, 15, 6, 2030, 1, 1, 1, 32, 3, 2001));
    send_word(make_word(csd_pkg::ACTION_TICK, 1, 0, 15, 6, 2030, 1, 1, 1, 5, 0, 2001));
    send_word(make_word(csd_pkg::ACTION_TICK, 1, 0, 15, 6, 2030, 1, 1, 1, 5, 13, 2001));
    send_word(make_word(csd_pkg::ACTION_TICK, 1, 86399, 31, 12, 4095, 255, 255, 255, 255,
                        255, 65535));
    send_word(make_word(csd_pkg::ACTION_TICK, 1, 86399, 31, 12, 2099, 23, 59, 59, 31, 12,
                        2099));
    send_word(make_word(csd_pkg::ACTION_TICK, 1, 3662, 15, 6, 2030, 1, 1, 1, 15, 6, 2030));
    send_word(make_word(csd_pkg::ACTION_TICK, 1, 0, 15, 6, 2030, 5, 0, 5, 15, 6, 2030));
    send_word(make_word(csd_pkg::ACTION_TICK, 1, 0, 15, 6, 2030, 5, 5, 0, 15, 6, 2030));
    send_word(make_word(csd_pkg::ACTION_TICK, 1, 0, 15, 6, 2030, 24, 1, 1, 15, 6, 2030));
    drain();

    // Random phases over several settings and idle patterns
    for (int p = 0; p < 8; p++) begin
      write_reg(csd_pkg::REG_LOCK_SECONDS, lock_plan[p]);
      write_reg(csd_pkg::REG_DRIFT_LIMIT, drift_plan[p]);
      send_idle  = idle_plan[p];
      recv_stall = stall_plan[p];
      if (hold_plan[p]) hold_req = 1'b1;
      repeat (130) send_word(rand_word(sb.drift_lim));
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.bad_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
design/csd_pkg.sv
design/csd_regs.sv
design/csd_eval.sv
design/clock_sync_decider.sv
bench/clock_sync_decider_tb.sv
